// File: sv/msadpcm_pkg.sv
// Shared types, constants and lookup tables for the MS ADPCM block decoder.
// No dependencies; every other file of the decoder refers to this package.
`default_nettype none

package msadpcm_pkg;

  // Parameter defaults.
  localparam int MAX_CH_DEFAULT    = 2;
  localparam int NUM_COEFS_DEFAULT = 7;
  localparam int QUEUE_DEPTH       = 4;

  // Number of coefficient pairs in the predictor table.
  localparam int TABLE_PAIRS      = 7;
  // Header length contributed by each channel.
  localparam int HDR_BYTES_PER_CH = 7;

  localparam int POS_W      = 12;
  localparam int BB_W       = 13;
  localparam int SPB_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [BB_W-1:0]  BB_MAX     = 13'd4096;
  localparam logic             STEREO_RST = 1'b0;
  localparam logic [BB_W-1:0]  BB_RST     = 13'd256;
  localparam logic [SPB_W-1:0] SPB_RST    = 14'd500;

  localparam logic signed [20:0] SAT_MAX     = 21'sd32767;
  localparam logic signed [20:0] SAT_MIN     = -21'sd32768;
  localparam logic signed [15:0] DELTA_FLOOR = 16'sd16;
  localparam logic [7:0]         HI_NIB_MASK = 8'hf0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEREO      = 2'd0,
    CFG_BLOCK_BYTES = 2'd1,
    CFG_SAMPLES     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             stereo;
    logic [BB_W-1:0]  block_bytes;
    logic [SPB_W-1:0] samples_per_block;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_SET_PI,
    OP_SET_DELTA,
    OP_SET_NEWEST,
    OP_SET_OLDER,
    OP_HDR,
    OP_BAD,
    OP_DATA
  } cmd_op_t;

  // One command from the byte parser to the sample engine. value holds the
  // assembled 16-bit header word, or the predictor / data byte in its low bits.
  typedef struct packed {
    cmd_op_t     op;
    logic        ch;
    logic        bad_ch;
    logic        stereo;
    logic        two_nib;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               channel;
    logic               status;
    logic               last;
  } res_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  function automatic logic signed [10:0] coef1(input logic [7:0] pi);
    logic signed [10:0] c;
    unique case (pi)
      8'd0:    c = 11'sd256;
      8'd1:    c = 11'sd512;
      8'd2:    c = 11'sd0;
      8'd3:    c = 11'sd192;
      8'd4:    c = 11'sd240;
      8'd5:    c = 11'sd460;
      8'd6:    c = 11'sd392;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [10:0] coef2(input logic [7:0] pi);
    logic signed [10:0] c;
    unique case (pi)
      8'd0:    c = 11'sd0;
      8'd1:    c = -11'sd256;
      8'd2:    c = 11'sd0;
      8'd3:    c = 11'sd64;
      8'd4:    c = 11'sd0;
      8'd5:    c = -11'sd208;
      8'd6:    c = -11'sd232;
      default: c = 11'sd0;
    endcase
    return c;
  endfunction

  function automatic logic [9:0] gain(input logic [3:0] nib);
    logic [9:0] g;
    unique case (nib)
      4'd4:    g = 10'd307;
      4'd5:    g = 10'd409;
      4'd6:    g = 10'd512;
      4'd7:    g = 10'd614;
      4'd8:    g = 10'd768;
      4'd9:    g = 10'd614;
      4'd10:   g = 10'd512;
      4'd11:   g = 10'd409;
      4'd12:   g = 10'd307;
      default: g = 10'd230;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: sv/ms_adpcm_block_decoder.sv
// Top level of the 4-bit MS ADPCM block decoder: configuration registers,
// byte parser, command queue, sample engine and result queue. Uses msadpcm_pkg.
`default_nettype none

// The decoder takes an encoded MS ADPCM stream one byte per beat on a queue-style
// input (push/full) and returns decoded 16-bit samples on a queue-style output
// (empty/pop). Each block opens with a header of seven bytes per channel:
// predictor indexes, then little-endian initial delta, newest and older sample
// for each channel. The byte that completes the header yields the header samples,
// older of every channel first, then newest. Every later byte yields two nibbles,
// high first; in stereo the high nibble belongs to channel 0 and the low nibble
// to channel 1. Nibbles beyond samples_per_block are dropped without a result.
// If a predictor index is out of range when the header completes, a single
// result with status 1 and sample 0 names the first bad channel, and the rest
// of the block is skipped. The last result caused by a byte carries last = 1.
// Throughput: the parser takes one byte per cycle while its four-entry command
// queue has room. The sample engine decodes one nibble per cycle while the result
// queue has room, through a single shared datapath, so a data byte is decoded as
// two nibbles in turn (one in mono when only one nibble is left in the block);
// a header-load byte only loads state and the header-completing byte yields two
// results in mono and four in stereo. The engine thus sets the data-part rate.
// Configuration is written through the cfg_ port (always ready) and must only
// change while no results are pending. A four-entry result queue decouples the
// engine from the consumer.

module ms_adpcm_block_decoder #(
  parameter int MAX_CHANNELS = msadpcm_pkg::MAX_CH_DEFAULT,
  parameter int NUM_COEFS    = msadpcm_pkg::NUM_COEFS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [15:0]                  out_pcm_sample,
  output logic                                out_channel,
  output logic                                out_status,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msadpcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msadpcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  msadpcm_pkg::cfg_t cfg_r;
  msadpcm_pkg::cmd_t front_cmd, back_cmd;
  msadpcm_pkg::res_t back_res, out_res;
  logic              byte_ready;
  logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic              res_push, res_full;

  // Configuration registers; writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stereo            <= msadpcm_pkg::STEREO_RST;
      cfg_r.block_bytes       <= msadpcm_pkg::BB_RST;
      cfg_r.samples_per_block <= msadpcm_pkg::SPB_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msadpcm_pkg::CFG_STEREO:      cfg_r.stereo <= cfg_data[0];
        msadpcm_pkg::CFG_BLOCK_BYTES: cfg_r.block_bytes <= cfg_data[msadpcm_pkg::BB_W-1:0];
        msadpcm_pkg::CFG_SAMPLES:
          cfg_r.samples_per_block <= cfg_data[msadpcm_pkg::SPB_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full = !byte_ready;

  // Front: parse bytes into commands.
  msadpcm_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .NUM_COEFS    (NUM_COEFS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (in_push),
    .data_byte  (in_data_byte),
    .byte_ready (byte_ready),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  // Command queue lets the parser run ahead of the sample engine.
  msadpcm_fifo #(
    .WIDTH ($bits(msadpcm_pkg::cmd_t)),
    .DEPTH (msadpcm_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (back_cmd),
    .empty   (cmd_empty)
  );

  // Back: apply header loads and produce samples.
  msadpcm_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Result queue decouples the engine from the consumer.
  msadpcm_fifo #(
    .WIDTH ($bits(msadpcm_pkg::res_t)),
    .DEPTH (msadpcm_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_res),
    .empty   (out_empty)
  );

  assign out_pcm_sample = out_res.pcm;
  assign out_channel    = out_res.channel;
  assign out_status     = out_res.status;
  assign out_last       = out_res.last;

  // A reset cycle leaves no stale result on the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A bad-predictor report is a lone result with a zero sample.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |-> (out_last && (out_pcm_sample == 16'sd0)))
    else $error("bad-predictor beat not last or nonzero");

  // Channel 1 results appear only in stereo mode.
  a_right_needs_stereo: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_channel) |-> cfg_r.stereo)
    else $error("channel 1 result while configured for mono");

  // The engine never starts work while the command queue is empty.
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// File: sv/msadpcm_fifo.sv
// Small synchronous queue used between the decoder stages and on the output.
// Depends on msadpcm_pkg for its default width and depth.
`default_nettype none

module msadpcm_fifo #(
  parameter int WIDTH = $bits(msadpcm_pkg::cmd_t),
  parameter int DEPTH = msadpcm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/msadpcm_front.sv
// Byte parser: tracks the position in the block, assembles header words and
// turns every byte into at most one command for the sample engine. Uses msadpcm_pkg.
`default_nettype none

module msadpcm_front #(
  parameter int MAX_CHANNELS = msadpcm_pkg::MAX_CH_DEFAULT,
  parameter int NUM_COEFS    = msadpcm_pkg::NUM_COEFS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msadpcm_pkg::cfg_t   cfg,
  input  logic                byte_valid,
  input  logic [7:0]          data_byte,
  output logic                byte_ready,
  input  logic                cmd_full,
  output logic                cmd_push,
  output msadpcm_pkg::cmd_t   cmd
);

  logic [msadpcm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [msadpcm_pkg::SPB_W-1:0] sd_r, sd_nxt;
  logic [7:0]                    hold_r, hold_nxt;
  logic                          skip_r, skip_nxt;
  logic [7:0]                    pi_r [MAX_CHANNELS];
  logic                          pi_wr;

  logic                          accept;
  logic                          nch2;
  logic [3:0]                    hdr_len;
  logic [1:0]                    nch_len;
  logic [3:0]                    off;
  logic [1:0]                    grp;
  logic                          in_hdr;
  logic                          hdr_end;
  logic                          skip_eff;
  logic [MAX_CHANNELS-1:0]       bad_vec;
  logic                          bad0, bad1;
  logic                          two_nib;
  logic [msadpcm_pkg::BB_W-1:0]  bb_eff;
  logic [msadpcm_pkg::BB_W-1:0]  pos_inc;

  assign byte_ready = !cmd_full;
  assign accept     = byte_valid && !cmd_full;

  assign nch2    = cfg.stereo && (MAX_CHANNELS >= 2);
  assign hdr_len = nch2 ? 4'(2 * msadpcm_pkg::HDR_BYTES_PER_CH)
                        : 4'(msadpcm_pkg::HDR_BYTES_PER_CH);
  assign nch_len = nch2 ? 2'd2 : 2'd1;
  assign in_hdr  = pos_r < {8'd0, hdr_len};
  assign hdr_end = pos_r == {8'd0, hdr_len - 4'd1};
  assign off     = pos_r[3:0] - {2'b00, nch_len};
  assign grp     = nch2 ? off[3:2] : off[2:1];
  assign skip_eff = (pos_r == '0) ? 1'b0 : skip_r;

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      bad_vec[c] = (pi_r[c] >= 8'(NUM_COEFS)) || (pi_r[c] >= 8'(msadpcm_pkg::TABLE_PAIRS));
    end
  end
  assign bad0 = bad_vec[0];
  assign bad1 = nch2 && bad_vec[MAX_CHANNELS-1];

  assign two_nib = ({1'b0, sd_r} + 15'd1) < {1'b0, cfg.samples_per_block};

  assign bb_eff  = (cfg.block_bytes > msadpcm_pkg::BB_MAX) ? msadpcm_pkg::BB_MAX
                                                          : cfg.block_bytes;
  assign pos_inc = {1'b0, pos_r} + 13'd1;

  always_comb begin
    cmd.op      = msadpcm_pkg::OP_DATA;
    cmd.ch      = 1'b0;
    cmd.bad_ch  = 1'b0;
    cmd.stereo  = nch2;
    cmd.two_nib = 1'b0;
    cmd.value   = {8'd0, data_byte};
    cmd_push    = 1'b0;
    pi_wr       = 1'b0;
    pos_nxt     = pos_r;
    sd_nxt      = sd_r;
    hold_nxt    = hold_r;
    skip_nxt    = skip_r;
    if (accept) begin
      skip_nxt = skip_eff;
      if (in_hdr) begin
        if (pos_r < {10'd0, nch_len}) begin
          cmd.op   = msadpcm_pkg::OP_SET_PI;
          cmd.ch   = pos_r[0];
          cmd_push = 1'b1;
          pi_wr    = 1'b1;
        end else if (!off[0]) begin
          hold_nxt = data_byte;
        end else begin
          cmd.value = {data_byte, hold_r};
          cmd.ch    = nch2 & off[1];
          cmd_push  = 1'b1;
          unique case (grp)
            2'd0:    cmd.op = msadpcm_pkg::OP_SET_DELTA;
            2'd1:    cmd.op = msadpcm_pkg::OP_SET_NEWEST;
            default: cmd.op = msadpcm_pkg::OP_SET_OLDER;
          endcase
          // The last header byte also completes the older sample of the last channel.
          if (hdr_end) begin
            if (bad0 || bad1) begin
              cmd.op     = msadpcm_pkg::OP_BAD;
              cmd.bad_ch = !bad0;
              skip_nxt   = 1'b1;
            end else begin
              cmd.op = msadpcm_pkg::OP_HDR;
              sd_nxt = msadpcm_pkg::SPB_W'(2);
            end
          end
        end
      end else if (!skip_eff && (sd_r < cfg.samples_per_block)) begin
        cmd_push = 1'b1;
        if (nch2) begin
          sd_nxt = sd_r + 1'b1;
        end else begin
          cmd.two_nib = two_nib;
          sd_nxt      = two_nib ? sd_r + 2'd2 : sd_r + 2'd1;
        end
      end
      pos_nxt = (pos_inc >= bb_eff) ? '0 : pos_inc[msadpcm_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sd_r   <= '0;
      hold_r <= '0;
      skip_r <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        pi_r[c] <= '0;
      end
    end else begin
      pos_r  <= pos_nxt;
      sd_r   <= sd_nxt;
      hold_r <= hold_nxt;
      skip_r <= skip_nxt;
      if (pi_wr) begin
        pi_r[pos_r[0]] <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/msadpcm_back.sv
// Sample engine: holds per-channel predictor state, applies header loads from
// the command queue; one result per cycle unless res_full. Uses msadpcm_pkg.
`default_nettype none

module msadpcm_back #(
  parameter int MAX_CHANNELS = msadpcm_pkg::MAX_CH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  msadpcm_pkg::cmd_t   cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output msadpcm_pkg::res_t   res
);

  msadpcm_pkg::back_state_t state_r, state_nxt;
  logic [1:0]               step_r, step_nxt;
  msadpcm_pkg::cmd_t        cur_r;

  logic [7:0]         pi_r     [MAX_CHANNELS];
  logic signed [15:0] delta_r  [MAX_CHANNELS];
  logic signed [15:0] newest_r [MAX_CHANNELS];
  logic signed [15:0] older_r  [MAX_CHANNELS];

  logic               run, is_last, done, starts_run;
  logic [1:0]         last_idx;
  logic               rd_ch;
  logic [7:0]         hi_bits;
  logic [3:0]         nib;
  logic signed [3:0]  nib_s;
  logic signed [15:0] d_cur, nw_cur, od_cur;
  logic [7:0]         pi_cur;
  logic signed [10:0] c1, c2;
  logic signed [26:0] p1, p2;
  logic signed [27:0] psum;
  logic signed [19:0] pred, nprod;
  logic signed [20:0] s_wide;
  logic signed [15:0] s_sat;
  logic [9:0]         g;
  logic signed [26:0] gprod;
  logic signed [15:0] dl_wrap, dl_new;
  logic               sel_newest;

  assign run = (state_r == msadpcm_pkg::BK_RUN);

  always_comb begin
    unique case (cur_r.op)
      msadpcm_pkg::OP_HDR:  last_idx = cur_r.stereo ? 2'd3 : 2'd1;
      msadpcm_pkg::OP_DATA: last_idx = (cur_r.stereo || cur_r.two_nib) ? 2'd1 : 2'd0;
      default:              last_idx = 2'd0;
    endcase
  end

  assign is_last    = (step_r == last_idx);
  assign res_push   = run && !res_full;
  assign done       = res_push && is_last;
  assign cmd_pop    = cmd_valid && (!run || done);
  assign starts_run = (cmd.op == msadpcm_pkg::OP_HDR) || (cmd.op == msadpcm_pkg::OP_BAD)
                      || (cmd.op == msadpcm_pkg::OP_DATA);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msadpcm_pkg::BK_IDLE: begin
        if (cmd_pop && starts_run) begin
          state_nxt = msadpcm_pkg::BK_RUN;
        end
      end
      msadpcm_pkg::BK_RUN: begin
        if (done) begin
          state_nxt = (cmd_pop && starts_run) ? msadpcm_pkg::BK_RUN : msadpcm_pkg::BK_IDLE;
        end
      end
      default: state_nxt = msadpcm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (cmd_pop) begin
      step_nxt = 2'd0;
    end else if (res_push) begin
      step_nxt = step_r + 1'b1;
    end
  end

  // Nibble decode datapath: one nibble per cycle unless res_full stalls.
  assign rd_ch   = cur_r.stereo & step_r[0];
  assign hi_bits = cur_r.value[7:0] & msadpcm_pkg::HI_NIB_MASK;
  assign nib     = step_r[0] ? cur_r.value[3:0] : hi_bits[7:4];
  assign nib_s   = $signed(nib);
  assign d_cur   = delta_r[rd_ch];
  assign nw_cur  = newest_r[rd_ch];
  assign od_cur  = older_r[rd_ch];
  assign pi_cur  = pi_r[rd_ch];
  assign c1      = msadpcm_pkg::coef1(pi_cur);
  assign c2      = msadpcm_pkg::coef2(pi_cur);
  assign p1      = nw_cur * c1;
  assign p2      = od_cur * c2;
  assign psum    = {p1[26], p1} + {p2[26], p2};
  assign pred    = psum[27:8];
  assign nprod   = nib_s * d_cur;
  assign s_wide  = {pred[19], pred} + {nprod[19], nprod};
  assign g       = msadpcm_pkg::gain(nib);
  assign gprod   = $signed({1'b0, g}) * d_cur;
  assign dl_wrap = gprod[23:8];
  assign dl_new  = (dl_wrap < msadpcm_pkg::DELTA_FLOOR) ? msadpcm_pkg::DELTA_FLOOR : dl_wrap;

  always_comb begin
    if (s_wide > msadpcm_pkg::SAT_MAX) begin
      s_sat = 16'sd32767;
    end else if (s_wide < msadpcm_pkg::SAT_MIN) begin
      s_sat = -16'sd32768;
    end else begin
      s_sat = s_wide[15:0];
    end
  end

  assign sel_newest = cur_r.stereo ? step_r[1] : step_r[0];

  // Outputs.
  always_comb begin
    res.last    = is_last;
    res.channel = rd_ch;
    res.status  = 1'b0;
    unique case (cur_r.op)
      msadpcm_pkg::OP_HDR:  res.pcm = sel_newest ? nw_cur : od_cur;
      msadpcm_pkg::OP_DATA: res.pcm = s_sat;
      msadpcm_pkg::OP_BAD: begin
        res.pcm     = '0;
        res.channel = cur_r.bad_ch;
        res.status  = 1'b1;
      end
      default: res.pcm = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msadpcm_pkg::BK_IDLE;
      step_r  <= 2'd0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        pi_r[c]     <= '0;
        delta_r[c]  <= '0;
        newest_r[c] <= '0;
        older_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (res_push && (cur_r.op == msadpcm_pkg::OP_DATA)) begin
        delta_r[rd_ch]  <= dl_new;
        older_r[rd_ch]  <= nw_cur;
        newest_r[rd_ch] <= s_sat;
      end
      // A command popped this cycle is younger than the one finishing, so its
      // load is applied last.
      if (cmd_pop) begin
        unique case (cmd.op)
          msadpcm_pkg::OP_SET_PI:     pi_r[cmd.ch]     <= cmd.value[7:0];
          msadpcm_pkg::OP_SET_DELTA:  delta_r[cmd.ch]  <= cmd.value;
          msadpcm_pkg::OP_SET_NEWEST: newest_r[cmd.ch] <= cmd.value;
          msadpcm_pkg::OP_SET_OLDER,
          msadpcm_pkg::OP_HDR,
          msadpcm_pkg::OP_BAD:        older_r[cmd.ch]  <= cmd.value;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
  end

endmodule

`default_nettype wire
